>>> src/tclc_pkg.sv
// Shared constants, types and register codes for the light conditioner.
package tclc_pkg;

	localparam int ADC_BITS       = 10;
	localparam int AVG_SCALE_BITS = 3;
	localparam int GAIN_FRAC_BITS = 8;

	localparam int AVG_W   = ADC_BITS + AVG_SCALE_BITS;
	localparam int GAIN_W  = 10;
	localparam int SHIFT_W = 3;
	localparam int LEVEL_W = 10;
	localparam int STEER_W = LEVEL_W + 1;
	localparam int PROD_W  = ADC_BITS + GAIN_W;
	localparam int SCALED_W = PROD_W - GAIN_FRAC_BITS;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;

	localparam logic [ADC_BITS-1:0] SAMPLE_MAX = {ADC_BITS{1'b1}};
	localparam logic [LEVEL_W-1:0]  LEVEL_MAX  = LEVEL_W'(1023);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_SHIFT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_HIGH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_LEFT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_CENTRE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_RIGHT   = 3'd4;

	localparam logic [SHIFT_W-1:0] SHIFT_RESET = 3'd3;
	localparam logic [GAIN_W-1:0]  GAIN_RESET  = GAIN_W'(256);

	typedef struct packed {
		logic [SHIFT_W-1:0] smoothing_shift;
		logic               brighter_is_higher;
		logic [GAIN_W-1:0]  gain_left;
		logic [GAIN_W-1:0]  gain_centre;
		logic [GAIN_W-1:0]  gain_right;
	} cfg_t;

endpackage

>>> src/three_channel_light_conditioner.sv
// Top level: input register, three channel units, result register.
// Path: input register, then result register; the result register loads once it is free or its content leaves.
// Throughput: one sample triple per cycle while out_stall is low; the averages update as an item
// leaves the input register, so the next item sees them at once.
// Reset clears valids and averages to zero and loads register defaults.
module three_channel_light_conditioner (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   restart,
	input  logic [tclc_pkg::ADC_BITS-1:0]          raw_left,
	input  logic [tclc_pkg::ADC_BITS-1:0]          raw_centre,
	input  logic [tclc_pkg::ADC_BITS-1:0]          raw_right,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [tclc_pkg::LEVEL_W-1:0]           level_left,
	output logic [tclc_pkg::LEVEL_W-1:0]           level_centre,
	output logic [tclc_pkg::LEVEL_W-1:0]           level_right,
	output logic signed [tclc_pkg::STEER_W-1:0]    steer_error,
	output logic [tclc_pkg::LEVEL_W-1:0]           peak_level,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [tclc_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [tclc_pkg::CFG_DATA_W-1:0]        cfg_data
);

	tclc_pkg::cfg_t cfg;

	logic                          valid_s1;
	logic                          restart_s1;
	logic [tclc_pkg::ADC_BITS-1:0] raw_left_s1;
	logic [tclc_pkg::ADC_BITS-1:0] raw_centre_s1;
	logic [tclc_pkg::ADC_BITS-1:0] raw_right_s1;

	logic                          adv;
	logic                          upd;
	logic [tclc_pkg::LEVEL_W-1:0]  lv_left;
	logic [tclc_pkg::LEVEL_W-1:0]  lv_centre;
	logic [tclc_pkg::LEVEL_W-1:0]  lv_right;
	logic [tclc_pkg::LEVEL_W-1:0]  lv_peak;

	logic                          out_valid_q;
	logic [tclc_pkg::LEVEL_W-1:0]  level_left_q;
	logic [tclc_pkg::LEVEL_W-1:0]  level_centre_q;
	logic [tclc_pkg::LEVEL_W-1:0]  level_right_q;
	logic signed [tclc_pkg::STEER_W-1:0] steer_q;
	logic [tclc_pkg::LEVEL_W-1:0]  peak_q;

	tclc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// result register free, or its content leaves this cycle
	assign adv      = !out_valid_q || !out_stall;
	assign upd      = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			restart_s1    <= restart;
			raw_left_s1   <= raw_left;
			raw_centre_s1 <= raw_centre;
			raw_right_s1  <= raw_right;
		end
	end

	tclc_chan u_left (
		.clk                (clk),
		.arst_n             (arst_n),
		.upd_en             (upd),
		.restart            (restart_s1),
		.raw                (raw_left_s1),
		.smoothing_shift    (cfg.smoothing_shift),
		.brighter_is_higher (cfg.brighter_is_higher),
		.gain               (cfg.gain_left),
		.level              (lv_left)
	);

	tclc_chan u_centre (
		.clk                (clk),
		.arst_n             (arst_n),
		.upd_en             (upd),
		.restart            (restart_s1),
		.raw                (raw_centre_s1),
		.smoothing_shift    (cfg.smoothing_shift),
		.brighter_is_higher (cfg.brighter_is_higher),
		.gain               (cfg.gain_centre),
		.level              (lv_centre)
	);

	tclc_chan u_right (
		.clk                (clk),
		.arst_n             (arst_n),
		.upd_en             (upd),
		.restart            (restart_s1),
		.raw                (raw_right_s1),
		.smoothing_shift    (cfg.smoothing_shift),
		.brighter_is_higher (cfg.brighter_is_higher),
		.gain               (cfg.gain_right),
		.level              (lv_right)
	);

	always_comb begin
		lv_peak = lv_left;
		if (lv_centre > lv_peak)
			lv_peak = lv_centre;
		if (lv_right > lv_peak)
			lv_peak = lv_right;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			level_left_q   <= lv_left;
			level_centre_q <= lv_centre;
			level_right_q  <= lv_right;
			steer_q        <= $signed({1'b0, lv_right}) - $signed({1'b0, lv_left});
			peak_q         <= lv_peak;
		end
	end

	assign out_valid    = out_valid_q;
	assign level_left   = level_left_q;
	assign level_centre = level_centre_q;
	assign level_right  = level_right_q;
	assign steer_error  = steer_q;
	assign peak_level   = peak_q;

endmodule

>>> src/tclc_cfg.sv
// Configuration register file.
module tclc_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tclc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tclc_pkg::CFG_DATA_W-1:0] cfg_data,
	output tclc_pkg::cfg_t                  cfg
);

	tclc_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.smoothing_shift    <= tclc_pkg::SHIFT_RESET;
			cfg_q.brighter_is_higher <= 1'b1;
			cfg_q.gain_left          <= tclc_pkg::GAIN_RESET;
			cfg_q.gain_centre        <= tclc_pkg::GAIN_RESET;
			cfg_q.gain_right         <= tclc_pkg::GAIN_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				tclc_pkg::REG_SMOOTH_SHIFT:
					cfg_q.smoothing_shift <= cfg_data[tclc_pkg::SHIFT_W-1:0];
				tclc_pkg::REG_BRIGHT_HIGH:  cfg_q.brighter_is_higher <= cfg_data[0];
				tclc_pkg::REG_GAIN_LEFT:    cfg_q.gain_left   <= cfg_data[tclc_pkg::GAIN_W-1:0];
				tclc_pkg::REG_GAIN_CENTRE:  cfg_q.gain_centre <= cfg_data[tclc_pkg::GAIN_W-1:0];
				tclc_pkg::REG_GAIN_RIGHT:   cfg_q.gain_right  <= cfg_data[tclc_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

>>> src/tclc_chan.sv
// One channel: moving average register, polarity, gain and clamp.
module tclc_chan (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              upd_en,
	input  logic                              restart,
	input  logic [tclc_pkg::ADC_BITS-1:0]     raw,
	input  logic [tclc_pkg::SHIFT_W-1:0]      smoothing_shift,
	input  logic                              brighter_is_higher,
	input  logic [tclc_pkg::GAIN_W-1:0]       gain,
	output logic [tclc_pkg::LEVEL_W-1:0]      level
);

	logic [tclc_pkg::AVG_W-1:0]        avg_q;
	logic [tclc_pkg::AVG_W-1:0]        target;
	logic [tclc_pkg::AVG_W-1:0]        avg_next;
	logic signed [tclc_pkg::AVG_W:0]   diff;
	logic signed [tclc_pkg::AVG_W:0]   delta;
	logic [tclc_pkg::ADC_BITS-1:0]     sample;
	logic [tclc_pkg::ADC_BITS-1:0]     oriented;
	logic [tclc_pkg::PROD_W-1:0]       prod;
	logic [tclc_pkg::SCALED_W-1:0]     scaled;

	always_comb begin
		target = tclc_pkg::AVG_W'(raw) << tclc_pkg::AVG_SCALE_BITS;
		diff   = $signed({1'b0, target}) - $signed({1'b0, avg_q});
		// arithmetic shift floors toward minus infinity
		delta  = diff >>> smoothing_shift;
		if (restart)
			avg_next = target;
		else
			avg_next = avg_q + delta[tclc_pkg::AVG_W-1:0];

		sample   = avg_next[tclc_pkg::AVG_W-1:tclc_pkg::AVG_SCALE_BITS];
		oriented = brighter_is_higher ? sample : tclc_pkg::SAMPLE_MAX - sample;
		prod     = tclc_pkg::PROD_W'(oriented) * tclc_pkg::PROD_W'(gain);
		scaled   = prod[tclc_pkg::PROD_W-1:tclc_pkg::GAIN_FRAC_BITS];
		if (scaled > tclc_pkg::SCALED_W'(tclc_pkg::LEVEL_MAX))
			level = tclc_pkg::LEVEL_MAX;
		else
			level = scaled[tclc_pkg::LEVEL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q <= '0;
		end else if (upd_en) begin
			avg_q <= avg_next;
		end
	end

endmodule
